// ----- rtl/pec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types and constants of the page entry update checker.
// ----------------------------------------------------------------------------
package pec_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int FRAME_W     = 40;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int ENTRY_W     = 64;

	// x86 entry bit positions
	localparam int PTE_P       = 0;
	localparam int PTE_RW      = 1;
	localparam int PTE_US      = 2;
	localparam int PTE_NX      = 63;
	localparam int FRAME_SHIFT = 12;

	typedef enum logic [1:0] {
		VIOL_NONE       = 2'd0,
		VIOL_USER_EXEC  = 2'd1,
		VIOL_WX_KERNEL  = 2'd2,
		VIOL_CODE_REMAP = 2'd3
	} viol_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} back_st_t;

	// classified request handed from front to back
	typedef struct packed {
		logic               is_load;    // append frame_a
		logic               user_exec;  // rule one already decided
		logic               chk_wx;     // rule two needs frame_a looked up
		logic               chk_remap;  // rule three needs frame_b looked up
		logic [FRAME_W-1:0] frame_a;    // append frame or new frame
		logic [FRAME_W-1:0] frame_b;    // old frame
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ----- rtl/pec_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pec_front
// Takes requests and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module pec_front (
	input  logic                        push,
	input  logic                        mode,
	input  logic [39:0]                 load_frame,
	input  logic [63:0]                 old_entry,
	input  logic [63:0]                 new_entry,
	output logic                        full,
	input  pec_pkg::q_status_t          q_status,
	output logic                        cmd_push,
	output pec_pkg::cmd_t               cmd
);
	import pec_pkg::*;

	logic new_p, user_now, write_now, exec_now, user_before, old_p;
	logic [FRAME_W-1:0] nf, of;

	always_comb begin
		new_p       = new_entry[PTE_P];
		user_now    = new_entry[PTE_US];
		write_now   = new_entry[PTE_RW];
		exec_now    = !new_entry[PTE_NX];
		user_before = old_entry[PTE_US];
		old_p       = old_entry[PTE_P];
		nf          = new_entry[FRAME_SHIFT +: FRAME_W];
		of          = old_entry[FRAME_SHIFT +: FRAME_W];
	end

	always_comb begin
		cmd = '0;
		if (!mode) begin
			cmd.is_load = 1'b1;
			cmd.frame_a = load_frame[FRAME_W-1:0];
		end else if (new_p) begin
			cmd.user_exec = user_before && !user_now && exec_now;
			cmd.chk_wx    = !user_now && write_now && exec_now;
			cmd.chk_remap = old_p && (nf != of);
			cmd.frame_a   = nf;
			cmd.frame_b   = of;
		end
	end

	assign full     = q_status.full;
	assign cmd_push = push && !q_status.full;

endmodule

`default_nettype wire

// ----- rtl/pec_cmd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pec_cmd_queue
// Two-entry queue of commands between front and back.
// ----------------------------------------------------------------------------
module pec_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  pec_pkg::cmd_t      wr_data,
	input  logic               rd_en,
	output pec_pkg::cmd_t      rd_data,
	output pec_pkg::q_status_t status
);
	import pec_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data      = slot_q[rd_ptr_q];
	assign status.full  = (fill_q == 2'd2);
	assign status.empty = (fill_q == 2'd0);

endmodule

`default_nettype wire

// ----- rtl/pec_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pec_back
// Holds the code frame table, runs appends and table scans, and keeps
// the result register.
// ----------------------------------------------------------------------------
module pec_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pec_pkg::cmd_t              cmd,
	input  pec_pkg::q_status_t         q_status,
	output logic                       cmd_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 violation,
	output logic                       load_accepted,
	output logic [10:0]                table_count
);
	import pec_pkg::*;

	logic [FRAME_W-1:0] mem [TABLE_DEPTH];

	back_st_t           state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   addr_q;
	cmd_t               cur_q;
	logic               known_nf_q, known_of_q;
	logic [FRAME_W-1:0] rd_data_s1;
	logic               rd_valid_s1;

	logic               res_valid_q;
	viol_t              res_viol_q;
	logic               res_acc_q;
	logic [CNT_W-1:0]   res_cnt_q;

	logic               res_free, start, direct, start_scan, last_issue;
	logic               room, mem_we, hit_nf, hit_of, kn, ko, res_load;
	viol_t              res_viol_d;
	logic               res_acc_d;
	logic [CNT_W-1:0]   res_cnt_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start_scan) state_d = ST_SCAN;
			ST_SCAN:  if (last_issue) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control and result selection
	always_comb begin
		res_free   = !res_valid_q || pop;
		start      = (state_q == ST_IDLE) && !q_status.empty && res_free;
		direct     = cmd.is_load || cmd.user_exec || !(cmd.chk_wx || cmd.chk_remap)
		             || (cnt_q == '0);
		start_scan = start && !direct;
		last_issue = (state_q == ST_SCAN) &&
		             ({{(CNT_W-IDX_W){1'b0}}, addr_q} == cnt_q - CNT_W'(1));
		room       = cnt_q < CNT_W'(TABLE_DEPTH);
		mem_we     = start && cmd.is_load && room;
		cmd_pop    = start;
		hit_nf     = rd_valid_s1 && (rd_data_s1 == cur_q.frame_a);
		hit_of     = rd_valid_s1 && (rd_data_s1 == cur_q.frame_b);
		kn         = known_nf_q || hit_nf;
		ko         = known_of_q || hit_of;
		res_load   = (start && direct) || (state_q == ST_DRAIN);

		res_viol_d = VIOL_NONE;
		res_acc_d  = 1'b0;
		res_cnt_d  = cnt_q;
		if (state_q == ST_DRAIN) begin
			priority if (cur_q.chk_wx && !kn)   res_viol_d = VIOL_WX_KERNEL;
			else if (cur_q.chk_remap && ko)     res_viol_d = VIOL_CODE_REMAP;
			else                                res_viol_d = VIOL_NONE;
		end else if (cmd.is_load) begin
			res_acc_d = room;
			res_cnt_d = cnt_q + {{(CNT_W-1){1'b0}}, room};
		end else begin
			// direct checks: the entry bits alone decide, or the table is empty and nothing is known
			priority if (cmd.user_exec) res_viol_d = VIOL_USER_EXEC;
			else if (cmd.chk_wx)        res_viol_d = VIOL_WX_KERNEL;
			else                        res_viol_d = VIOL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			known_nf_q  <= 1'b0;
			known_of_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (mem_we) cnt_q <= cnt_q + CNT_W'(1);
			if (start_scan) begin
				addr_q     <= '0;
				known_nf_q <= 1'b0;
				known_of_q <= 1'b0;
			end else begin
				if (state_q == ST_SCAN) addr_q <= addr_q + IDX_W'(1);
				known_nf_q <= kn;
				known_of_q <= ko;
			end
			if (res_load)       res_valid_q <= 1'b1;
			else if (pop)       res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) cur_q <= cmd;
		if (res_load) begin
			res_viol_q <= res_viol_d;
			res_acc_q  <= res_acc_d;
			res_cnt_q  <= res_cnt_d;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[cnt_q[IDX_W-1:0]] <= cmd.frame_a;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) rd_data_s1 <= mem[addr_q];
	end

	assign empty         = !res_valid_q;
	assign violation     = res_viol_q;
	assign load_accepted = res_acc_q;
	assign table_count   = res_cnt_q;

endmodule

`default_nettype wire

// ----- rtl/page_entry_update_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// page_entry_update_checker
// Code frame table and page table entry update classifier.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. An append (mode 0) stores the low
// 40 bits of load_frame in the next free slot of a 1024-entry table, or is
// refused once the table is full. A check (mode 1) reports a violation code
// from the old and new entries, using the x86 present, write, user and
// no-execute bits and the frame at bit 12. Checks decided by the entry bits
// alone, or made against an empty table, are answered without a scan. Any
// other check scans the filled part of the table one entry per cycle
// through the table's single read port. A two-entry command queue lets
// requests be taken while a scan runs, and a finished result waits in its
// own register until popped. Reset empties the table at once; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module page_entry_update_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [39:0] load_frame,
	input  logic [63:0] old_entry,
	input  logic [63:0] new_entry,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  violation,
	output logic        load_accepted,
	output logic [10:0] table_count
);
	import pec_pkg::*;

	cmd_t      cmd_in, cmd_out;
	logic      cmd_push, cmd_pop;
	q_status_t q_status;

	// front: accept and classify each request
	pec_front u_front (
		.push       (push),
		.mode       (mode),
		.load_frame (load_frame),
		.old_entry  (old_entry),
		.new_entry  (new_entry),
		.full       (full),
		.q_status   (q_status),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	// short queue decoupling front and back
	pec_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.status  (q_status)
	);

	// back: table appends, scans and the result register
	pec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_out),
		.q_status      (q_status),
		.cmd_pop       (cmd_pop),
		.empty         (empty),
		.pop           (pop),
		.violation     (violation),
		.load_accepted (load_accepted),
		.table_count   (table_count)
	);

endmodule

`default_nettype wire

// ----- tb/tb_page_entry_update_checker.sv -----
// ----------------------------------------------------------------------------
// tb_page_entry_update_checker
// Self-checking bench for the code frame table and entry update classifier.
// ----------------------------------------------------------------------------
// Requests are queued up front by a generator and fed to the block by a
// clocked driver. A clocked monitor pops results and checks them against a
// shadow copy of the code frame table. Both sides idle at random, with quiet
// stretches. The run takes a directed batch, then a mixed random batch, then
// stores one known frame after a full drain and checks against it.
// ----------------------------------------------------------------------------
module tb_page_entry_update_checker;

	timeunit 1ns;
	timeprecision 1ps;

	import pec_pkg::*;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_CHECK  = 1'b1;

	localparam int RANDOM_REQS = 460;
	localparam int LONG_HOLD   = 300;	// receiver stall to back the block up
	localparam int HOLD_AT_A   = 40;
	localparam int HOLD_AT_B   = 400;
	localparam int TAIL_CYCLES = 1100;	// a full-table scan and then some

	localparam logic [FRAME_W-1:0] ALL_ONES_FRAME = '1;
	localparam logic [FRAME_W-1:0] MID_FRAME      = 40'h00_1234_5678;
	localparam logic [FRAME_W-1:0] TOP_BIT_FRAME  = 40'h80_0000_0000;
	localparam logic [FRAME_W-1:0] LAST_FRAME     = 40'hA5_0000_0001;
	localparam logic [FRAME_W-1:0] REFUSED_FRAME  = 40'h77_7777_7777;

	typedef struct {
		logic               mode;
		logic [FRAME_W-1:0] load_frame;
		logic [ENTRY_W-1:0] old_entry;
		logic [ENTRY_W-1:0] new_entry;
		int                 gap;		// idle cycles before it is offered
		bit                 drain_first;	// hold it back until all results are in
	} request_t;

	typedef struct {
		viol_t            violation;
		logic             load_accepted;
		logic [CNT_W-1:0] table_count;
	} outcome_t;

	// DUT connections; every input starts at a known value
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               mode = MODE_APPEND;
	logic [FRAME_W-1:0] load_frame = '0;
	logic [ENTRY_W-1:0] old_entry = '0;
	logic [ENTRY_W-1:0] new_entry = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [1:0]         violation;
	logic               load_accepted;
	logic [CNT_W-1:0]   table_count;

	// shadow state of the block
	logic [FRAME_W-1:0] code_frames [TABLE_DEPTH];
	int                 held = 0;

	request_t           pending[$];		// requests not yet offered
	outcome_t           expected[$];		// outcomes of accepted requests
	logic [FRAME_W-1:0] planned_frames[$];	// frames the generator has queued to store
	int                 n_planned = 0;
	int                 n_sent = 0;
	int                 n_recv = 0;
	int                 errors = 0;
	int                 n_stored = 0;
	int                 n_refused = 0;
	int                 viol_seen [4] = '{0, 0, 0, 0};
	longint             cycle_limit = 64'd50_000_000;

	page_entry_update_checker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.load_frame   (load_frame),
		.old_entry    (old_entry),
		.new_entry    (new_entry),
		.empty        (empty),
		.pop          (pop),
		.violation    (violation),
		.load_accepted(load_accepted),
		.table_count  (table_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------

	// only the filled part of the table is searched
	function automatic bit frame_listed(input logic [FRAME_W-1:0] f);
		for (int i = 0; i < held && i < TABLE_DEPTH; i++)
			if (code_frames[i] == f)
				return 1'b1;
		return 1'b0;
	endfunction

	// applies one accepted request to the shadow table and returns its outcome
	function automatic outcome_t predict_outcome(input request_t r);
		outcome_t           o;
		logic [FRAME_W-1:0] new_frame;
		logic [FRAME_W-1:0] old_frame;
		logic               user_now;
		logic               write_now;
		logic               exec_now;
		o.violation     = VIOL_NONE;
		o.load_accepted = 1'b0;
		if (r.mode == MODE_APPEND) begin
			if (held < TABLE_DEPTH) begin
				code_frames[held] = r.load_frame;
				held++;
				o.load_accepted = 1'b1;
				n_stored++;
			end else begin
				n_refused++;
			end
		end else begin
			new_frame = r.new_entry[FRAME_SHIFT +: FRAME_W];
			old_frame = r.old_entry[FRAME_SHIFT +: FRAME_W];
			user_now  = r.new_entry[PTE_US];
			write_now = r.new_entry[PTE_RW];
			exec_now  = !r.new_entry[PTE_NX];
			// rules in priority order; a non-present new entry is never flagged
			if (!r.new_entry[PTE_P])
				o.violation = VIOL_NONE;
			else if (r.old_entry[PTE_US] && !user_now && exec_now)
				o.violation = VIOL_USER_EXEC;
			else if (!user_now && write_now && exec_now && !frame_listed(new_frame))
				o.violation = VIOL_WX_KERNEL;
			else if (r.old_entry[PTE_P] && new_frame != old_frame
					&& frame_listed(old_frame))
				o.violation = VIOL_CODE_REMAP;
			viol_seen[o.violation]++;
		end
		o.table_count = CNT_W'(held);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [ENTRY_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [FRAME_W-1:0] rand_frame();
		logic [ENTRY_W-1:0] w;
		w = rand_word();
		return w[FRAME_W-1:0];
	endfunction

	// builds an entry; bits outside the flags and the frame come from noise
	function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
			input logic p, input logic rw, input logic us, input logic nx,
			input logic [ENTRY_W-1:0] noise);
		logic [ENTRY_W-1:0] e;
		e = noise;
		e[FRAME_SHIFT +: FRAME_W] = frame;
		e[PTE_P]  = p;
		e[PTE_RW] = rw;
		e[PTE_US] = us;
		e[PTE_NX] = nx;
		return e;
	endfunction

	// half the time a frame that will be in the table, so lookups hit
	function automatic logic [FRAME_W-1:0] pick_frame();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5 && planned_frames.size() != 0)
			return planned_frames[$urandom_range(0, planned_frames.size() - 1)];
		if (k == 5)
			return FRAME_W'($urandom_range(0, 3));
		return rand_frame();
	endfunction

	task automatic queue_request(input logic m, input logic [FRAME_W-1:0] lf,
			input logic [ENTRY_W-1:0] oe, input logic [ENTRY_W-1:0] ne,
			input bit drain);
		request_t r;
		r.mode        = m;
		r.load_frame  = lf;
		r.old_entry   = oe;
		r.new_entry   = ne;
		r.drain_first = drain;
		// every third stretch of 40 requests goes back to back
		r.gap = (((n_planned / 40) % 3) == 2) ? 0 : $urandom_range(0, 9);
		if (m == MODE_APPEND && planned_frames.size() < TABLE_DEPTH)
			planned_frames.push_back(lf);
		pending.push_back(r);
		n_planned++;
	endtask

	task automatic queue_random_check(input bit drain);
		logic [FRAME_W-1:0] of;
		logic [FRAME_W-1:0] nf;
		of = pick_frame();
		nf = ($urandom_range(0, 9) < 3) ? of : pick_frame();
		queue_request(MODE_CHECK, rand_frame(),
			make_entry(of, $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_word()),
			make_entry(nf, $urandom_range(0, 6) != 0, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0, rand_word()),
			drain);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers the front of the pending queue once its gap has run out
	// ------------------------------------------------------------------
	request_t cur_req;

	always @(posedge clk or negedge arst_n) begin
		logic offering;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			offering = push;
			if (push && !full) begin
				expected.push_back(predict_outcome(cur_req));
				n_sent++;
				offering = 1'b0;
			end
			if (!offering && pending.size() != 0) begin
				if (pending[0].gap != 0) begin
					pending[0].gap--;
				end else if (!pending[0].drain_first || expected.size() == 0) begin
					cur_req    = pending.pop_front();
					mode       <= cur_req.mode;
					load_frame <= cur_req.load_frame;
					old_entry  <= cur_req.old_entry;
					new_entry  <= cur_req.new_entry;
					offering   = 1'b1;
				end
			end
			push <= offering;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: pops results with random waits and two long holds
	// ------------------------------------------------------------------
	int wait_left = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				n_recv++;
				if (expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected result violation %0d accepted %0d count %0d",
						$time, violation, load_accepted, table_count);
				end else begin
					want = expected.pop_front();
					if (violation !== want.violation) begin
						errors++;
						$display("%0t: violation mismatch, expected %0d got %0d",
							$time, want.violation, violation);
					end
					if (load_accepted !== want.load_accepted) begin
						errors++;
						$display("%0t: load_accepted mismatch, expected %0d got %0d",
							$time, want.load_accepted, load_accepted);
					end
					if (table_count !== want.table_count) begin
						errors++;
						$display("%0t: table_count mismatch, expected %0d got %0d",
							$time, want.table_count, table_count);
					end
				end
				wait_left = (((n_recv / 64) % 3) == 1) ? 0 : $urandom_range(0, 9);
				// sender keeps going meanwhile, so the block backs up and asserts full
				if (n_recv == HOLD_AT_A || n_recv == HOLD_AT_B)
					hold_left = LONG_HOLD;
			end else if (hold_left != 0) begin
				hold_left--;
			end else if (wait_left != 0) begin
				wait_left--;
			end
			pop <= (hold_left == 0 && wait_left == 0);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin : watchdog
		longint n;
		n = 0;
		while (n < cycle_limit) begin
			@(posedge clk);
			n++;
		end
		$display("FAIL page_entry_update_checker");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request plan and end of run
	// ------------------------------------------------------------------
	initial begin : plan
		logic [ENTRY_W-1:0] ones;
		ones = '1;

		// directed: empty-table checks first
		queue_request(MODE_CHECK, ALL_ONES_FRAME, '0, '0, 1'b0);
		// everything but present set: nothing runs
		queue_request(MODE_CHECK, '0, ones, ones ^ ENTRY_W'(1), 1'b0);
		// writable exec kernel against an empty table
		queue_request(MODE_CHECK, '0, '0, make_entry(MID_FRAME, 1, 1, 0, 0, '0), 1'b0);

		// appends, extremes and a duplicate; the first has its ignored entry fields all ones
		queue_request(MODE_APPEND, ALL_ONES_FRAME, ones, ones, 1'b0);
		queue_request(MODE_APPEND, '0, rand_word(), rand_word(), 1'b0);
		queue_request(MODE_APPEND, MID_FRAME, rand_word(), rand_word(), 1'b0);
		queue_request(MODE_APPEND, MID_FRAME, '0, '0, 1'b0);

		// user to kernel exec, old present and not present
		queue_request(MODE_CHECK, '0, make_entry('0, 1, 0, 1, 0, '0),
			make_entry('0, 1, 0, 0, 0, '0), 1'b0);
		queue_request(MODE_CHECK, '0, make_entry('0, 0, 0, 1, 0, '0),
			make_entry('0, 1, 0, 0, 0, '0), 1'b0);
		// same transition but no-exec: falls through to a code frame remap
		queue_request(MODE_CHECK, '0, make_entry(MID_FRAME, 1, 0, 1, 0, '0),
			make_entry(FRAME_W'(1), 1, 1, 0, 1, '0), 1'b0);
		// writable exec kernel on a listed frame is fine
		queue_request(MODE_CHECK, '0, '0, make_entry(ALL_ONES_FRAME, 1, 1, 0, 0, '0), 1'b0);
		// unlisted frame with every spare bit set
		queue_request(MODE_CHECK, '0, '0, make_entry(FRAME_W'(1), 1, 1, 0, 0, ones), 1'b0);
		// code frame moved to another frame
		queue_request(MODE_CHECK, '0, make_entry('0, 1, 1, 1, 1, '0),
			make_entry(TOP_BIT_FRAME, 1, 0, 1, 1, '0), 1'b0);
		// listed frame kept
		queue_request(MODE_CHECK, '0, make_entry(ALL_ONES_FRAME, 1, 1, 0, 0, '0),
			make_entry(ALL_ONES_FRAME, 1, 0, 1, 0, '0), 1'b0);
		queue_request(MODE_CHECK, ALL_ONES_FRAME, ones, ones, 1'b0);
		// all ones with user and no-exec cleared
		queue_request(MODE_CHECK, '0, ones,
			make_entry(ALL_ONES_FRAME, 1, 1, 0, 0, ones), 1'b0);
		// listed old frame but old not present: no remap
		queue_request(MODE_CHECK, '0, make_entry(ALL_ONES_FRAME, 0, 1, 0, 1, '0),
			make_entry(FRAME_W'(2), 1, 0, 1, 1, '0), 1'b0);
		// writable exec kernel wins over remap
		queue_request(MODE_CHECK, '0, make_entry(MID_FRAME, 1, 0, 0, 0, '0),
			make_entry(FRAME_W'(2), 1, 1, 0, 0, '0), 1'b0);
		// new entry not present hides everything
		queue_request(MODE_CHECK, '0, make_entry(MID_FRAME, 1, 0, 1, 0, '0),
			make_entry(FRAME_W'(2), 0, 1, 0, 0, '0), 1'b0);
		queue_request(MODE_APPEND, 40'h5A_5A5A_5A5A, rand_word(), rand_word(), 1'b0);

		// random mix, about a quarter appends; one request waits for a full drain
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: queue_request(MODE_APPEND, pick_frame(), rand_word(), rand_word(),
						i == RANDOM_REQS / 2);
					1: queue_request(MODE_APPEND, $urandom_range(0, 1) ? ALL_ONES_FRAME
						: FRAME_W'(1) << $urandom_range(0, FRAME_W - 1),
						rand_word(), rand_word(), i == RANDOM_REQS / 2);
					default: queue_request(MODE_APPEND, rand_frame(), rand_word(),
						rand_word(), i == RANDOM_REQS / 2);
				endcase
			end else begin
				queue_random_check(i == RANDOM_REQS / 2);
			end
		end

		// one known frame stored after a full drain
		queue_request(MODE_APPEND, LAST_FRAME, rand_word(), rand_word(), 1'b1);

		// closing checks, one on the frame just stored and one on an unlisted frame
		queue_request(MODE_CHECK, '0, '0, make_entry(LAST_FRAME, 1, 1, 0, 0, '0), 1'b0);
		queue_request(MODE_CHECK, '0, '0, make_entry(REFUSED_FRAME, 1, 1, 0, 0, '0), 1'b0);
		queue_request(MODE_CHECK, '0, make_entry(LAST_FRAME, 1, 0, 0, 1, '0),
			make_entry(MID_FRAME ^ FRAME_W'(8), 1, 0, 1, 1, '0), 1'b0);
		repeat (15)
			queue_random_check(1'b0);

		// slowest legal run: every request a full scan plus both sides' worst waits
		cycle_limit = 64'(n_planned) * (TABLE_DEPTH + 40) * 4 + 4 * LONG_HOLD + 20000;

		while (pending.size() != 0 || push || expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d frames stored, %0d appends refused, %0d results",
			n_sent, n_stored, n_refused, n_recv);
		$display("checks: %0d clean, %0d user-to-kernel exec, %0d W+X kernel, %0d remaps",
			viol_seen[VIOL_NONE], viol_seen[VIOL_USER_EXEC], viol_seen[VIOL_WX_KERNEL],
			viol_seen[VIOL_CODE_REMAP]);
		if (errors == 0)
			$display("PASS page_entry_update_checker");
		else
			$display("FAIL page_entry_update_checker");
		$finish;
	end

endmodule
